// ----- rtl/core/prmq_pkg.sv -----
package prmq_pkg;

    localparam logic [1:0] REQ_PUBLISH = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_FETCH   = 2'd2;
    localparam logic [1:0] REQ_ACK     = 2'd3;

    localparam logic [3:0] STS_PUBLISHED = 4'd0;
    localparam logic [3:0] STS_FULL      = 4'd1;
    localparam logic [3:0] STS_DELIVERED = 4'd2;
    localparam logic [3:0] STS_NONE      = 4'd3;
    localparam logic [3:0] STS_ACKED     = 4'd4;
    localparam logic [3:0] STS_RETRIED   = 4'd5;
    localparam logic [3:0] STS_DEAD      = 4'd6;
    localparam logic [3:0] STS_UNKNOWN   = 4'd7;
    localparam logic [3:0] STS_TICKED    = 4'd8;

    localparam logic [1:0] SLOT_FREE   = 2'd0;
    localparam logic [1:0] SLOT_QUEUED = 2'd1;
    localparam logic [1:0] SLOT_FLIGHT = 2'd2;

    localparam logic [1:0] REG_MAX_RETRIES = 2'd0;
    localparam logic [1:0] REG_VIS_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_RETRY_DELAY = 2'd2;
    localparam logic [1:0] REG_REQ_DELAY   = 2'd3;

    typedef struct packed {
        logic       start;
        logic       step;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic       last;
    } t_sts;

endpackage

// ----- rtl/core/prmq_ctrl.sv -----
module prmq_ctrl
    import prmq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE && r_ovalid)
        else $error("finish did not return to idle");
    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_SCAN)
        else $error("start did not begin scan");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.start, o_cmd.step, o_cmd.finish}))
        else $error("multiple commands");
endmodule

// ----- rtl/core/prmq_dp.sv -----
module prmq_dp
    import prmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_priority_req,
    input  logic [15:0] i_delay,
    input  logic [15:0] i_msg_id,
    input  logic        i_success,
    input  logic [3:0]  i_max_retries,
    input  logic [15:0] i_visibility_timeout,
    input  logic [15:0] i_retry_delay,
    input  logic [15:0] i_timeout_requeue_delay,
    output logic [3:0]  o_status,
    output logic [15:0] o_out_id,
    output logic [4:0]  o_requeued_count,
    output logic [15:0] o_dead_total
);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);

    logic [1:0]  r_stat [QUEUE_DEPTH];
    logic [15:0] r_id   [QUEUE_DEPTH];
    logic [3:0]  r_prio [QUEUE_DEPTH];
    logic [31:0] r_vis  [QUEUE_DEPTH];
    logic [31:0] r_dlv  [QUEUE_DEPTH];

    logic [1:0]  r_req;
    logic [3:0]  r_pri_in;
    logic [15:0] r_dly_in, r_mid;
    logic        r_ok;
    logic [IW-1:0] r_idx;
    logic        r_found;
    logic [IW-1:0] r_sel;
    logic [15:0] r_next_id;
    logic [31:0] r_time;
    logic [15:0] r_dead;
    logic [4:0]  r_rq;
    logic [3:0]  r_status;
    logic [15:0] r_oid;
    logic [4:0]  r_orq;

    logic [1:0]  c_st;
    logic        c_ahead, c_hit, c_to;

    assign c_st = r_stat[r_idx];
    assign c_to = (r_time - r_dlv[r_idx]) > {16'd0, i_visibility_timeout};
    always_comb begin
        if (r_prio[r_idx] != r_prio[r_sel]) c_ahead = r_prio[r_idx] > r_prio[r_sel];
        else if (r_vis[r_idx] != r_vis[r_sel]) c_ahead = r_vis[r_idx] < r_vis[r_sel];
        else c_ahead = r_id[r_idx] < r_id[r_sel];
        case (r_req)
            REQ_PUBLISH: c_hit = !r_found && c_st == SLOT_FREE;
            REQ_FETCH:   c_hit = c_st == SLOT_QUEUED && (!r_found || c_ahead);
            REQ_ACK:     c_hit = !r_found && c_st == SLOT_FLIGHT && r_id[r_idx] == r_mid;
            default:     c_hit = 1'b0;
        endcase
    end

    assign o_sts.last = (r_idx == LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) r_stat[k] <= SLOT_FREE;
            r_next_id <= '0;
            r_time    <= '0;
            r_dead    <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
        end else if (i_cmd.start) begin
            r_req    <= i_req_type;
            r_pri_in <= i_priority_req;
            r_dly_in <= i_delay;
            r_mid    <= i_msg_id;
            r_ok     <= i_success;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_sel    <= '0;
            r_rq     <= '0;
            if (i_req_type == REQ_TICK) r_time <= r_time + 32'd1;
        end else if (i_cmd.step) begin
            if (!o_sts.last) r_idx <= r_idx + 1'b1;
            if (r_req == REQ_TICK) begin
                if (c_st == SLOT_FLIGHT && c_to) begin
                    r_stat[r_idx] <= SLOT_QUEUED;
                    r_vis[r_idx]  <= r_time + {16'd0, i_timeout_requeue_delay};
                    if (r_rq != 5'd31) r_rq <= r_rq + 5'd1;
                end
            end else if (c_hit) begin
                r_found <= 1'b1;
                r_sel   <= r_idx;
            end
        end else if (i_cmd.finish) begin
            r_orq <= (r_req == REQ_TICK) ? r_rq : 5'd0;
            case (r_req)
                REQ_PUBLISH: begin
                    if (!r_found) begin
                        r_oid    <= '0;
                        r_status <= STS_FULL;
                    end else begin
                        r_stat[r_sel] <= SLOT_QUEUED;
                        r_id[r_sel]   <= r_next_id;
                        r_prio[r_sel] <= r_pri_in;
                        r_vis[r_sel]  <= r_time + {16'd0, r_dly_in};
                        r_oid         <= r_next_id;
                        r_next_id     <= r_next_id + 16'd1;
                        r_status      <= STS_PUBLISHED;
                    end
                end
                REQ_TICK: begin
                    r_oid    <= '0;
                    r_status <= STS_TICKED;
                end
                REQ_FETCH: begin
                    if (!r_found || r_vis[r_sel] > r_time) begin
                        r_oid    <= '0;
                        r_status <= STS_NONE;
                    end else begin
                        r_stat[r_sel] <= SLOT_FLIGHT;
                        r_dlv[r_sel]  <= r_time;
                        r_oid         <= r_id[r_sel];
                        r_status      <= STS_DELIVERED;
                    end
                end
                default: begin
                    r_oid <= r_mid;
                    if (!r_found) r_status <= STS_UNKNOWN;
                    else if (r_ok) begin
                        r_stat[r_sel] <= SLOT_FREE;
                        r_status      <= STS_ACKED;
                    end else if (r_prio[r_sel] < i_max_retries) begin
                        r_prio[r_sel] <= r_prio[r_sel] + 4'd1;
                        r_vis[r_sel]  <= r_time + {16'd0, i_retry_delay};
                        r_stat[r_sel] <= SLOT_QUEUED;
                        r_status      <= STS_RETRIED;
                    end else begin
                        r_stat[r_sel] <= SLOT_FREE;
                        if (r_dead != 16'hFFFF) r_dead <= r_dead + 16'd1;
                        r_status      <= STS_DEAD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) o_dead_total <= (r_req == REQ_ACK && r_found && !r_ok &&
            !(r_prio[r_sel] < i_max_retries) && r_dead != 16'hFFFF) ? r_dead + 16'd1 : r_dead;
    end

    assign o_status         = r_status;
    assign o_out_id         = r_oid;
    assign o_requeued_count = r_orq;

    a_tick_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start && i_req_type == REQ_TICK |=> r_time == $past(r_time) + 32'd1)
        else $error("tick did not advance time");
    a_dead_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_dead >= $past(r_dead))
        else $error("dead counter decreased");
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_sel <= LAST)
        else $error("selection out of range");
endmodule

// ----- rtl/core/priority_retry_message_queue.sv -----
// Message queue with priority order and visibility timeouts. Each request
// beat is handled in steps: the request is latched, the slot table is
// scanned sequentially one slot at a time, and then the update is applied
// and the result registered once the output register is free. A new beat
// is taken once the result is loaded into the output register.
module priority_retry_message_queue
    import prmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_priority_req,
    input  logic [15:0] i_delay,
    input  logic [15:0] i_msg_id,
    input  logic        i_success,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [15:0] o_out_id,
    output logic [4:0]  o_requeued_count,
    output logic [15:0] o_dead_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd        cmd;
    t_sts        sts;
    logic [3:0]  r_max_retries;
    logic [15:0] r_vis_to, r_retry_dly, r_rq_dly;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries <= 4'd3;
            r_vis_to      <= 16'd2000;
            r_retry_dly   <= 16'd500;
            r_rq_dly      <= 16'd200;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MAX_RETRIES: r_max_retries <= pwdata[3:0];
                REG_VIS_TIMEOUT: r_vis_to      <= pwdata[15:0];
                REG_RETRY_DELAY: r_retry_dly   <= pwdata[15:0];
                default:         r_rq_dly      <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_RETRIES: prdata = {28'd0, r_max_retries};
            REG_VIS_TIMEOUT: prdata = {16'd0, r_vis_to};
            REG_RETRY_DELAY: prdata = {16'd0, r_retry_dly};
            default:         prdata = {16'd0, r_rq_dly};
        endcase
    end

    prmq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_sts(sts), .o_cmd(cmd)
    );

    prmq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_req_type, .i_priority_req, .i_delay, .i_msg_id, .i_success,
        .i_max_retries(r_max_retries), .i_visibility_timeout(r_vis_to),
        .i_retry_delay(r_retry_dly), .i_timeout_requeue_delay(r_rq_dly),
        .o_status, .o_out_id, .o_requeued_count, .o_dead_total
    );
endmodule
